// ===== hdl/gdfw_pkg.sv =====
// Shared constants and types for the depth-first graph walk block.
package gdfw_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int MAX_EDGES_DEF    = 128;
    localparam int RESULT_CAP       = 64;
    localparam int TIME_W           = 6;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_WALK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [1:0] KIND_DISC = 2'd0;
    localparam logic [1:0] KIND_TIME = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_ADD_LINK,
        S_ACK,
        S_W_INIT,
        S_W_TOP,
        S_W_STEP,
        S_W_EDGE,
        S_W_PUSH,
        S_W_POP,
        S_R_RD,
        S_R_EMIT
    } t_state;

endpackage

// ===== hdl/gdfw_edge_store.sv =====
// Edge pool: head vertex and next-edge link per edge, one write and one read port.
module gdfw_edge_store #(
    parameter int MAX_EDGES = gdfw_pkg::MAX_EDGES_DEF,
    parameter int VW        = 5
) (
    input  logic                           i_clk,
    input  logic                           i_wr_head_en,
    input  logic                           i_wr_link_en,
    input  logic [$clog2(MAX_EDGES)-1:0]   i_wr_addr,
    input  logic [VW-1:0]                  i_wr_head,
    input  logic [$clog2(MAX_EDGES+1)-1:0] i_wr_link,
    input  logic                           i_rd_en,
    input  logic [$clog2(MAX_EDGES)-1:0]   i_rd_addr,
    output logic [VW-1:0]                  o_rd_head,
    output logic [$clog2(MAX_EDGES+1)-1:0] o_rd_link
);

    localparam int EW = $clog2(MAX_EDGES + 1);

    logic [VW-1:0] head_mem [MAX_EDGES];
    logic [EW-1:0] link_mem [MAX_EDGES];

    always_ff @(posedge i_clk) begin
        if (i_wr_head_en) begin
            head_mem[i_wr_addr] <= i_wr_head;
        end
        if (i_wr_link_en) begin
            link_mem[i_wr_addr] <= i_wr_link;
        end
        if (i_rd_en) begin
            o_rd_head <= head_mem[i_rd_addr];
            o_rd_link <= link_mem[i_rd_addr];
        end
    end

endmodule

// ===== hdl/graph_depth_first_walk_top.sv =====
// Top level of the depth-first graph walk block.
//
// Holds a directed graph as per-vertex edge lists and walks it depth first.
// One item is in work at a time; the input is ready only while idle. An edge
// add reads the list ends, writes the edge and list ends, links the old tail
// when the list has one, then loads its acknowledgement; clear, unused
// commands and rejected items load it directly. A walk emits the source,
// tests each edge of the top vertex, emits each vertex it discovers, finishes
// each vertex whose list is done, then emits a time record per vertex; a
// record waits while the receiver holds the output register, but past the
// record cap it is dropped. Each step reads the edge pool, list-end, stack or
// time memory through a register. Visited marks and list-valid bits are
// flip-flops, so no clearing pass is needed after reset, clear or walk start.
module graph_depth_first_walk_top #(
    parameter int MAX_VERTICES = gdfw_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = gdfw_pkg::MAX_EDGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [4:0] i_from_vertex,
    input  logic [4:0] i_to_vertex,
    input  logic [4:0] i_source_vertex,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_record_kind,
    output logic [4:0] o_vertex_id,
    output logic       o_reached,
    output logic [5:0] o_discover_time,
    output logic [5:0] o_finish_time,
    output logic [1:0] o_status,
    output logic       o_last
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int EA = $clog2(MAX_EDGES);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int TW = gdfw_pkg::TIME_W;
    localparam logic [EW-1:0] NIL = EW'(MAX_EDGES);
    localparam logic [CW-1:0] VMAX = CW'(MAX_VERTICES);
    localparam logic [6:0] CAP = 7'(gdfw_pkg::RESULT_CAP);

    // control and bookkeeping
    gdfw_pkg::t_state r_state, n_state;
    logic [5:0]        r_vcount;
    logic [VW-1:0]     r_a, n_a;
    logic [VW-1:0]     r_b, n_b;
    logic [1:0]        r_ack_stat, n_ack_stat;
    logic [EW-1:0]     r_used, n_used;
    logic [MAX_VERTICES-1:0] r_lv, r_vis;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_depth, n_depth;
    logic [TW-1:0]     r_time, n_time;
    logic [VW-1:0]     r_top_v, n_top_v;
    logic [EW-1:0]     r_top_cur, n_top_cur;
    logic [6:0]        r_n, n_n;
    logic [CW-1:0]     r_ri, n_ri;

    // output register
    logic       r_o_valid;
    logic [1:0] r_o_kind;
    logic [4:0] r_o_vid;
    logic       r_o_reach;
    logic [5:0] r_o_disc, r_o_fin;
    logic [1:0] r_o_stat;
    logic       r_o_last;

    // memories
    logic [EW-1:0] lf_mem [MAX_VERTICES];
    logic [EW-1:0] ll_mem [MAX_VERTICES];
    logic [TW-1:0] disc_mem [MAX_VERTICES];
    logic [TW-1:0] fin_mem [MAX_VERTICES];
    logic [VW-1:0] stv_mem [MAX_VERTICES];
    logic [EW-1:0] stc_mem [MAX_VERTICES];
    logic [EW-1:0] r_lf_rd, r_ll_rd;
    logic          r_lv_rd;
    logic [TW-1:0] r_disc_rd, r_fin_rd;
    logic [VW-1:0] r_stv_rd;
    logic [EW-1:0] r_stc_rd;
    logic [VW-1:0] ed_head;
    logic [EW-1:0] ed_link;

    // combinational controls
    logic          l_rd_en, lf_we, ll_we, lv_clr, lv_set;
    logic [VW-1:0] l_rd_addr, l_wa;
    logic          ed_head_we, ed_link_we, ed_rd_en;
    logic [EA-1:0] ed_wa, ed_ra;
    logic [EW-1:0] ed_wlink;
    logic          dw_en, fw_en, t_rd_en;
    logic [VW-1:0] t_wa, t_ra;
    logic [TW-1:0] t_wd;
    logic          st_we, st_rd_en;
    logic [VW-1:0] st_wa, st_ra;
    logic          vis_clr, vis_set;
    logic [VW-1:0] vis_addr;
    logic [MAX_VERTICES-1:0] vis_onehot;
    logic          e_load;
    logic [1:0]    e_kind, e_stat;
    logic [4:0]    e_vid;
    logic          e_reach, e_final;
    logic [TW-1:0] e_disc, e_fin;
    logic          slot_free, capped, emit_go;
    logic [CW-1:0] eff;
    logic          a_ok, b_ok, s_ok, w_new;
    logic [TW-1:0] time_inc;

    assign eff = ({3'b0, r_vcount} > 9'(MAX_VERTICES)) ? VMAX : CW'(r_vcount);
    assign a_ok = {4'b0, i_from_vertex} < 9'(eff);
    assign b_ok = {4'b0, i_to_vertex} < 9'(eff);
    assign s_ok = {4'b0, i_source_vertex} < 9'(eff);
    assign slot_free = !r_o_valid || i_out_ready;
    assign capped = (r_n >= CAP);
    assign emit_go = slot_free || capped;
    assign time_inc = r_time + TW'(1);
    assign w_new = (CW'(ed_head) < r_cnt) && !r_vis[ed_head] && (r_depth < VMAX);
    assign o_in_ready = (r_state == gdfw_pkg::S_IDLE);
    assign vis_onehot = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << vis_addr;

    always_comb begin
        n_state    = r_state;
        n_a        = r_a;
        n_b        = r_b;
        n_ack_stat = r_ack_stat;
        n_used     = r_used;
        n_cnt      = r_cnt;
        n_depth    = r_depth;
        n_time     = r_time;
        n_top_v    = r_top_v;
        n_top_cur  = r_top_cur;
        n_n        = r_n;
        n_ri       = r_ri;
        l_rd_en    = 1'b0;
        l_rd_addr  = r_a;
        lf_we      = 1'b0;
        ll_we      = 1'b0;
        l_wa       = r_a;
        lv_clr     = 1'b0;
        lv_set     = 1'b0;
        ed_head_we = 1'b0;
        ed_link_we = 1'b0;
        ed_wa      = r_used[EA-1:0];
        ed_wlink   = NIL;
        ed_rd_en   = 1'b0;
        ed_ra      = r_top_cur[EA-1:0];
        dw_en      = 1'b0;
        fw_en      = 1'b0;
        t_wa       = r_top_v;
        t_wd       = time_inc;
        t_rd_en    = 1'b0;
        t_ra       = VW'(r_ri);
        st_we      = 1'b0;
        st_wa      = VW'(r_depth - CW'(1));
        st_rd_en   = 1'b0;
        st_ra      = VW'(r_depth - CW'(2));
        vis_clr    = 1'b0;
        vis_set    = 1'b0;
        vis_addr   = ed_head;
        e_load     = 1'b0;
        e_kind     = gdfw_pkg::KIND_ACK;
        e_vid      = 5'd0;
        e_reach    = 1'b0;
        e_disc     = '0;
        e_fin      = '0;
        e_stat     = r_ack_stat;
        e_final    = 1'b0;

        unique case (r_state)
            gdfw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cnt      = eff;
                    n_n        = '0;
                    n_ack_stat = gdfw_pkg::ST_OK;
                    priority if (i_cmd == gdfw_pkg::CMD_ADD) begin
                        n_a = VW'(i_from_vertex);
                        n_b = VW'(i_to_vertex);
                        priority if (!a_ok || !b_ok) begin
                            n_ack_stat = gdfw_pkg::ST_RANGE;
                            n_state    = gdfw_pkg::S_ACK;
                        end else if (r_used == NIL) begin
                            n_ack_stat = gdfw_pkg::ST_FULL;
                            n_state    = gdfw_pkg::S_ACK;
                        end else begin
                            l_rd_en   = 1'b1;
                            l_rd_addr = VW'(i_from_vertex);
                            n_state   = gdfw_pkg::S_ADD_RD;
                        end
                    end else if (i_cmd == gdfw_pkg::CMD_WALK) begin
                        n_a = VW'(i_source_vertex);
                        if (s_ok) begin
                            n_state = gdfw_pkg::S_W_INIT;
                        end else begin
                            n_ack_stat = gdfw_pkg::ST_RANGE;
                            n_state    = gdfw_pkg::S_ACK;
                        end
                    end else if (i_cmd == gdfw_pkg::CMD_CLEAR) begin
                        lv_clr  = 1'b1;
                        n_used  = '0;
                        n_state = gdfw_pkg::S_ACK;
                    end else begin
                        n_state = gdfw_pkg::S_ACK;
                    end
                end
            end
            gdfw_pkg::S_ADD_RD: begin
                n_state = gdfw_pkg::S_ADD_WR;
            end
            gdfw_pkg::S_ADD_WR: begin
                ed_head_we = 1'b1;
                ed_link_we = 1'b1;
                lf_we      = !r_lv_rd;
                ll_we      = 1'b1;
                lv_set     = 1'b1;
                n_state    = r_lv_rd ? gdfw_pkg::S_ADD_LINK : gdfw_pkg::S_ACK;
                if (!r_lv_rd) begin
                    n_used = r_used + EW'(1);
                end
            end
            gdfw_pkg::S_ADD_LINK: begin
                // chain the previous tail of this list to the new edge
                ed_link_we = 1'b1;
                ed_wa      = r_ll_rd[EA-1:0];
                ed_wlink   = r_used;
                n_used     = r_used + EW'(1);
                n_state    = gdfw_pkg::S_ACK;
            end
            gdfw_pkg::S_ACK: begin
                if (slot_free) begin
                    e_load  = 1'b1;
                    e_final = 1'b1;
                    n_state = gdfw_pkg::S_IDLE;
                end
            end
            gdfw_pkg::S_W_INIT: begin
                if (emit_go) begin
                    vis_clr   = 1'b1;
                    vis_set   = 1'b1;
                    vis_addr  = r_a;
                    n_time    = '0;
                    dw_en     = 1'b1;
                    t_wa      = r_a;
                    t_wd      = '0;
                    l_rd_en   = 1'b1;
                    e_load    = 1'b1;
                    e_kind    = gdfw_pkg::KIND_DISC;
                    e_vid     = 5'(r_a);
                    e_reach   = 1'b1;
                    e_stat    = gdfw_pkg::ST_OK;
                    n_state   = gdfw_pkg::S_W_TOP;
                end
            end
            gdfw_pkg::S_W_TOP: begin
                n_top_v   = r_a;
                n_top_cur = r_lv_rd ? r_lf_rd : NIL;
                n_depth   = CW'(1);
                n_state   = gdfw_pkg::S_W_STEP;
            end
            gdfw_pkg::S_W_STEP: begin
                if (r_top_cur >= NIL) begin
                    // list exhausted: finish the top vertex and pop
                    n_time  = time_inc;
                    fw_en   = 1'b1;
                    n_depth = r_depth - CW'(1);
                    if (r_depth == CW'(1)) begin
                        n_ri    = '0;
                        n_state = gdfw_pkg::S_R_RD;
                    end else begin
                        st_rd_en = 1'b1;
                        n_state  = gdfw_pkg::S_W_POP;
                    end
                end else begin
                    ed_rd_en = 1'b1;
                    n_state  = gdfw_pkg::S_W_EDGE;
                end
            end
            gdfw_pkg::S_W_EDGE: begin
                if (!w_new) begin
                    n_top_cur = ed_link;
                    n_state   = gdfw_pkg::S_W_STEP;
                end else if (emit_go) begin
                    vis_set   = 1'b1;
                    n_time    = time_inc;
                    dw_en     = 1'b1;
                    t_wa      = ed_head;
                    st_we     = 1'b1;
                    n_top_v   = ed_head;
                    n_a       = ed_head;
                    l_rd_en   = 1'b1;
                    l_rd_addr = ed_head;
                    e_load    = 1'b1;
                    e_kind    = gdfw_pkg::KIND_DISC;
                    e_vid     = 5'(ed_head);
                    e_reach   = 1'b1;
                    e_disc    = time_inc;
                    e_stat    = gdfw_pkg::ST_OK;
                    n_state   = gdfw_pkg::S_W_PUSH;
                end
            end
            gdfw_pkg::S_W_PUSH: begin
                n_top_cur = r_lv_rd ? r_lf_rd : NIL;
                n_depth   = r_depth + CW'(1);
                n_state   = gdfw_pkg::S_W_STEP;
            end
            gdfw_pkg::S_W_POP: begin
                n_top_v   = r_stv_rd;
                n_top_cur = r_stc_rd;
                n_state   = gdfw_pkg::S_W_STEP;
            end
            gdfw_pkg::S_R_RD: begin
                t_rd_en = 1'b1;
                n_state = gdfw_pkg::S_R_EMIT;
            end
            gdfw_pkg::S_R_EMIT: begin
                if (emit_go) begin
                    e_load  = 1'b1;
                    e_kind  = gdfw_pkg::KIND_TIME;
                    e_vid   = 5'(r_ri);
                    e_reach = r_vis[VW'(r_ri)];
                    e_disc  = r_vis[VW'(r_ri)] ? r_disc_rd : '0;
                    e_fin   = r_vis[VW'(r_ri)] ? r_fin_rd : '0;
                    e_stat  = gdfw_pkg::ST_OK;
                    e_final = (r_ri == r_cnt - CW'(1));
                    n_ri    = r_ri + CW'(1);
                    n_state = e_final ? gdfw_pkg::S_IDLE : gdfw_pkg::S_R_RD;
                end
            end
            default: n_state = gdfw_pkg::S_IDLE;
        endcase

        if (e_load && !capped) begin
            n_n = r_n + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gdfw_pkg::S_IDLE;
            r_vcount <= 6'd32;
            r_used   <= '0;
            r_lv     <= '0;
            r_vis    <= '0;
            r_depth  <= '0;
            r_time   <= '0;
            r_n      <= '0;
            r_ri     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            r_used  <= n_used;
            r_depth <= n_depth;
            r_time  <= n_time;
            r_n     <= n_n;
            r_ri    <= n_ri;
            if (lv_clr) begin
                r_lv <= '0;
            end else if (lv_set) begin
                r_lv[l_wa] <= 1'b1;
            end
            // a new walk keeps only the source mark
            if (vis_clr) begin
                r_vis <= vis_onehot;
            end else if (vis_set) begin
                r_vis <= r_vis | vis_onehot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_ack_stat <= n_ack_stat;
        r_cnt      <= n_cnt;
        r_top_v    <= n_top_v;
        r_top_cur  <= n_top_cur;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (e_load && !capped) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_load && !capped) begin
            r_o_kind  <= e_kind;
            r_o_vid   <= e_vid;
            r_o_reach <= e_reach;
            r_o_disc  <= e_disc;
            r_o_fin   <= e_fin;
            r_o_stat  <= e_stat;
            r_o_last  <= e_final || (r_n == CAP - 7'd1);
        end
    end

    // list ends
    always_ff @(posedge i_clk) begin
        if (lf_we) begin
            lf_mem[l_wa] <= r_used;
        end
        if (ll_we) begin
            ll_mem[l_wa] <= r_used;
        end
        if (l_rd_en) begin
            r_lf_rd <= lf_mem[l_rd_addr];
            r_ll_rd <= ll_mem[l_rd_addr];
            r_lv_rd <= r_lv[l_rd_addr];
        end
    end

    // discovery and finish times
    always_ff @(posedge i_clk) begin
        if (dw_en) begin
            disc_mem[t_wa] <= t_wd;
        end
        if (fw_en) begin
            fin_mem[t_wa] <= t_wd;
        end
        if (t_rd_en) begin
            r_disc_rd <= disc_mem[t_ra];
            r_fin_rd  <= fin_mem[t_ra];
        end
    end

    // walk stack below the top entry, which lives in r_top_v / r_top_cur
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            stv_mem[st_wa] <= r_top_v;
            stc_mem[st_wa] <= ed_link;
        end
        if (st_rd_en) begin
            r_stv_rd <= stv_mem[st_ra];
            r_stc_rd <= stc_mem[st_ra];
        end
    end

    gdfw_edge_store #(
        .MAX_EDGES (MAX_EDGES),
        .VW        (VW)
    ) u_edges (
        .i_clk        (i_clk),
        .i_wr_head_en (ed_head_we),
        .i_wr_link_en (ed_link_we),
        .i_wr_addr    (ed_wa),
        .i_wr_head    (r_b),
        .i_wr_link    (ed_wlink),
        .i_rd_en      (ed_rd_en),
        .i_rd_addr    (ed_ra),
        .o_rd_head    (ed_head),
        .o_rd_link    (ed_link)
    );

    assign o_out_valid     = r_o_valid;
    assign o_record_kind   = r_o_kind;
    assign o_vertex_id     = r_o_vid;
    assign o_reached       = r_o_reach;
    assign o_discover_time = r_o_disc;
    assign o_finish_time   = r_o_fin;
    assign o_status        = r_o_stat;
    assign o_last          = r_o_last;

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= VMAX)
        else $error("walk stack deeper than vertex count");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_depth == '0))
        else $error("walk stack not empty while idle");

    a_no_revisit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gdfw_pkg::S_W_EDGE && vis_set) |-> !r_vis[ed_head])
        else $error("vertex discovered twice");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NIL)
        else $error("edge count beyond pool size");
`endif

endmodule

// ===== tb/graph_depth_first_walk_checker.sv =====
// Checker for the depth-first walk block: predicts records and compares transfers.
`timescale 1ns / 100ps
module graph_depth_first_walk_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [4:0] i_from_vertex,
    input  logic [4:0] i_to_vertex,
    input  logic [4:0] i_source_vertex,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_record_kind,
    input  logic [4:0] i_vertex_id,
    input  logic       i_reached,
    input  logic [5:0] i_discover_time,
    input  logic [5:0] i_finish_time,
    input  logic [1:0] i_status,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int NV = gdfw_pkg::MAX_VERTICES_DEF;
    localparam int NE = gdfw_pkg::MAX_EDGES_DEF;
    localparam int QD = 256;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] vid;
        logic       reached;
        logic [5:0] disc;
        logic [5:0] fin;
        logic [1:0] status;
        logic       last;
    } t_record;

    // expected records, kept as a ring
    t_record     exp_ring[QD];
    int unsigned exp_wr;
    int unsigned exp_rd;

    int unsigned head_of[NE];
    int unsigned link_of[NE];
    int unsigned first_of[NV];
    int unsigned last_of[NV];
    int unsigned n_edges;
    int unsigned n_vert;
    bit          seen[NV];
    logic [5:0]  disc_t[NV];
    logic [5:0]  fin_t[NV];

    assign o_pending = int'(exp_wr - exp_rd);

    task automatic report(input string what);
        $display("%0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic void add_rec(input logic [1:0] k, input int unsigned v,
                                    input bit r, input logic [5:0] d,
                                    input logic [5:0] f, input logic [1:0] st,
                                    input bit lst);
        t_record rec;
        rec = '{k, v[4:0], r, d, f, st, lst};
        exp_ring[exp_wr % QD] = rec;
        exp_wr++;
    endfunction

    function automatic void empty_lists();
        for (int i = 0; i < NV; i++) begin
            first_of[i] = NE;
            last_of[i] = NE;
        end
        n_edges = 0;
    endfunction

    function automatic void predict_walk(input int unsigned src, input int unsigned cnt);
        int unsigned sv[NV];
        int unsigned sc[NV];
        int unsigned depth;
        int unsigned v;
        int unsigned cur;
        int unsigned w;
        logic [5:0] clock_t;
        int         nrec;
        nrec = 0;
        for (int i = 0; i < NV; i++) begin
            seen[i] = 0;
            disc_t[i] = '0;
            fin_t[i] = '0;
        end
        clock_t = '0;
        seen[src] = 1;
        add_rec(gdfw_pkg::KIND_DISC, src, 1'b1, 6'd0, 6'd0, gdfw_pkg::ST_OK, 1'b0);
        nrec++;
        sv[0] = src;
        sc[0] = first_of[src];
        depth = 1;
        while (depth > 0) begin
            v = sv[depth-1];
            cur = sc[depth-1];
            if (cur >= NE) begin
                depth--;
                clock_t++;
                fin_t[v] = clock_t;
            end else begin
                w = head_of[cur];
                sc[depth-1] = link_of[cur];
                if (w < cnt && !seen[w] && depth < NV) begin
                    seen[w] = 1;
                    clock_t++;
                    disc_t[w] = clock_t;
                    if (nrec < gdfw_pkg::RESULT_CAP) begin
                        add_rec(gdfw_pkg::KIND_DISC, w, 1'b1, clock_t, 6'd0,
                                gdfw_pkg::ST_OK, 1'b0);
                        nrec++;
                    end
                    sv[depth] = w;
                    sc[depth] = first_of[w];
                    depth++;
                end
            end
        end
        for (int unsigned i = 0; i < cnt; i++) begin
            if (nrec < gdfw_pkg::RESULT_CAP) begin
                add_rec(gdfw_pkg::KIND_TIME, i, seen[i], seen[i] ? disc_t[i] : 6'd0,
                        seen[i] ? fin_t[i] : 6'd0, gdfw_pkg::ST_OK, 1'b0);
                nrec++;
            end
        end
        exp_ring[(exp_wr - 1) % QD].last = 1'b1;
    endfunction

    function automatic void predict_item(input logic [1:0] cmd, input int unsigned a,
                                         input int unsigned b, input int unsigned s);
        int unsigned cnt;
        int unsigned e;
        cnt = n_vert > NV ? NV : n_vert;
        unique case (cmd)
            gdfw_pkg::CMD_ADD: begin
                if (a >= cnt || b >= cnt) begin
                    add_rec(gdfw_pkg::KIND_ACK, 0, 1'b0, 6'd0, 6'd0, gdfw_pkg::ST_RANGE, 1'b1);
                end else if (n_edges >= NE) begin
                    add_rec(gdfw_pkg::KIND_ACK, 0, 1'b0, 6'd0, 6'd0, gdfw_pkg::ST_FULL, 1'b1);
                end else begin
                    e = n_edges++;
                    head_of[e] = b;
                    link_of[e] = NE;
                    if (last_of[a] >= NE) first_of[a] = e;
                    else link_of[last_of[a]] = e;
                    last_of[a] = e;
                    add_rec(gdfw_pkg::KIND_ACK, 0, 1'b0, 6'd0, 6'd0, gdfw_pkg::ST_OK, 1'b1);
                end
            end
            gdfw_pkg::CMD_WALK: begin
                if (s >= cnt)
                    add_rec(gdfw_pkg::KIND_ACK, 0, 1'b0, 6'd0, 6'd0, gdfw_pkg::ST_RANGE, 1'b1);
                else
                    predict_walk(s, cnt);
            end
            gdfw_pkg::CMD_CLEAR: begin
                empty_lists();
                add_rec(gdfw_pkg::KIND_ACK, 0, 1'b0, 6'd0, 6'd0, gdfw_pkg::ST_OK, 1'b1);
            end
            default: add_rec(gdfw_pkg::KIND_ACK, 0, 1'b0, 6'd0, 6'd0, gdfw_pkg::ST_OK, 1'b1);
        endcase
    endfunction

    initial begin
        o_fail_count = 0;
        exp_wr = 0;
        exp_rd = 0;
        n_vert = 32;
        empty_lists();
    end

    always @(posedge i_clk) begin
        t_record got;
        t_record want;
        if (i_rst_n) begin
            if (i_cfg_we) n_vert = i_cfg_data;
            if (i_in_valid && i_in_ready)
                predict_item(i_cmd, i_from_vertex, i_to_vertex, i_source_vertex);
            if (i_out_valid && i_out_ready) begin
                got = '{i_record_kind, i_vertex_id, i_reached, i_discover_time,
                        i_finish_time, i_status, i_last};
                if (exp_wr == exp_rd) begin
                    report($sformatf("unexpected record %h", got));
                end else begin
                    want = exp_ring[exp_rd % QD];
                    exp_rd++;
                    if (got.kind != want.kind)
                        report($sformatf("kind %0d want %0d", got.kind, want.kind));
                    if (got.vid != want.vid)
                        report($sformatf("vertex %0d want %0d", got.vid, want.vid));
                    if (got.reached != want.reached)
                        report($sformatf("reached %0d want %0d v%0d", got.reached,
                                         want.reached, want.vid));
                    if (got.disc != want.disc)
                        report($sformatf("discover %0d want %0d v%0d", got.disc,
                                         want.disc, want.vid));
                    if (got.fin != want.fin)
                        report($sformatf("finish %0d want %0d v%0d", got.fin,
                                         want.fin, want.vid));
                    if (got.status != want.status)
                        report($sformatf("status %0d want %0d", got.status, want.status));
                    if (got.last != want.last)
                        report($sformatf("last %0d want %0d", got.last, want.last));
                end
            end
        end
    end

endmodule

// ===== tb/graph_depth_first_walk_top_tb.sv =====
// Testbench top for the depth-first walk block: stimulus and verdict.
`timescale 1ns / 100ps
module graph_depth_first_walk_top_tb;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       cfg_we = 0;
    logic [5:0] cfg_data = '0;
    logic       in_valid = 0;
    logic       in_ready;
    logic [1:0] cmd = '0;
    logic [4:0] from_v = '0;
    logic [4:0] to_v = '0;
    logic [4:0] src_v = '0;
    logic       out_valid;
    logic       out_ready = 0;
    logic [1:0] record_kind;
    logic [4:0] vertex_id;
    logic       reached;
    logic [5:0] discover_time;
    logic [5:0] finish_time;
    logic [1:0] status;
    logic       last;
    int         fail_count;
    int         pending;
    bit         stim_done = 0;
    int         vcount;

    always begin
        #1 clk = 1;
        #1 clk = 0;
    end

    graph_depth_first_walk_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_cmd(cmd),
        .i_from_vertex(from_v), .i_to_vertex(to_v), .i_source_vertex(src_v),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_record_kind(record_kind), .o_vertex_id(vertex_id), .o_reached(reached),
        .o_discover_time(discover_time), .o_finish_time(finish_time),
        .o_status(status), .o_last(last)
    );

    graph_depth_first_walk_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_cmd(cmd),
        .i_from_vertex(from_v), .i_to_vertex(to_v), .i_source_vertex(src_v),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_record_kind(record_kind), .i_vertex_id(vertex_id), .i_reached(reached),
        .i_discover_time(discover_time), .i_finish_time(finish_time),
        .i_status(status), .i_last(last), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // receiver: random stall before each transfer, with calm stretches
    initial begin
        int gap;
        @(posedge clk iff rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk iff out_valid);
        end
    end

    // valid stays up after the transfer; the next send or drain drops or reloads it
    task automatic send(input logic [1:0] c, input int a, input int b, input int s);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        cmd <= c;
        from_v <= a[4:0];
        to_v <= b[4:0];
        src_v <= s[4:0];
        @(posedge clk iff in_ready);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk iff pending == 0);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_count(input int n);
        drain();
        cfg_we <= 1;
        cfg_data <= n[5:0];
        @(posedge clk);
        cfg_we <= 0;
        vcount = n;
    endtask

    // random graph of about n_add edges, then a walk
    task automatic graph_burst(input int n_add);
        int lim;
        lim = vcount == 0 ? 1 : (vcount > 32 ? 32 : vcount);
        send(gdfw_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
        for (int i = 0; i < n_add; i++) begin
            if ($urandom_range(0, 15) == 0)
                send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            else
                send(gdfw_pkg::CMD_ADD, $urandom_range(0, lim-1),
                     $urandom_range(0, lim-1), 0);
        end
        send(gdfw_pkg::CMD_WALK, 0, 0,
             $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, lim-1));
    endtask

    initial begin
        vcount = 32;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty walk, extremes, chain, all commands
        send(gdfw_pkg::CMD_WALK, 0, 0, 31);
        send(gdfw_pkg::CMD_ADD, 0, 31, 0);
        send(gdfw_pkg::CMD_ADD, 31, 0, 0);
        send(gdfw_pkg::CMD_ADD, 0, 0, 0);
        send(gdfw_pkg::CMD_ADD, 0, 31, 0);
        send(gdfw_pkg::CMD_ADD, 31, 5, 0);
        send(gdfw_pkg::CMD_WALK, 0, 0, 0);
        send(gdfw_pkg::CMD_SPARE, 31, 31, 31);
        set_count(4);
        send(gdfw_pkg::CMD_ADD, 4, 0, 0);
        send(gdfw_pkg::CMD_ADD, 0, 4, 0);
        send(gdfw_pkg::CMD_WALK, 0, 0, 4);
        send(gdfw_pkg::CMD_ADD, 1, 2, 0);
        send(gdfw_pkg::CMD_ADD, 2, 3, 0);
        send(gdfw_pkg::CMD_WALK, 0, 0, 31);  // source 31 out of range: rejected
        send(gdfw_pkg::CMD_WALK, 0, 0, 1);
        set_count(0);
        send(gdfw_pkg::CMD_ADD, 0, 0, 0);
        send(gdfw_pkg::CMD_WALK, 0, 0, 0);
        set_count(63);
        send(gdfw_pkg::CMD_CLEAR, 0, 0, 0);
        // fill the edge store and overflow it
        for (int i = 0; i < 130; i++)
            send(gdfw_pkg::CMD_ADD, i % 32, (i * 7 + 1) % 32, 0);
        send(gdfw_pkg::CMD_WALK, 0, 0, 0);
        set_count(1);
        send(gdfw_pkg::CMD_CLEAR, 0, 0, 0);
        send(gdfw_pkg::CMD_ADD, 0, 0, 0);
        send(gdfw_pkg::CMD_WALK, 0, 0, 0);

        // random phases over several vertex counts
        for (int ph = 0; ph < 8; ph++) begin
            set_count(ph == 0 ? 32 : (ph == 1 ? 2 : $urandom_range(1, 40)));
            for (int g = 0; g < 2; g++)
                graph_burst($urandom_range(3, 20));
        end
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (fail_count == 0)
            $display("graph_depth_first_walk_top: match");
        else
            $display("graph_depth_first_walk_top: mismatch");
        $finish;
    end

    initial begin
        #4000000;
        $display("graph_depth_first_walk_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/gdfw_pkg.sv
hdl/gdfw_edge_store.sv
hdl/graph_depth_first_walk_top.sv
tb/graph_depth_first_walk_checker.sv
tb/graph_depth_first_walk_top_tb.sv
